// File: src/sta_pkg.sv
`timescale 1ns / 1ps
package sta_pkg;

  // Result kinds.
  localparam logic [2:0] KindReport  = 3'd0;
  localparam logic [2:0] KindStats   = 3'd1;
  localparam logic [2:0] KindSame    = 3'd2;
  localparam logic [2:0] KindChanged = 3'd3;
  localparam logic [2:0] KindInsert  = 3'd4;
  localparam logic [2:0] KindDropped = 3'd5;

  // Request types.
  localparam logic ReqScan  = 1'b0;
  localparam logic ReqCheck = 1'b1;

  // Register addresses.
  localparam logic [1:0] RegMaxAge = 2'd0;

  typedef enum logic [2:0] {
    StIdle,
    StSearch,
    StRead,
    StDecide,
    StCheckRead,
    StCheckDecide,
    StOut,
    StStats
  } state_e;

  // Mask of the bytes of one advert word that lie below the length.
  function automatic logic [63:0] byte_mask(logic [4:0] len, logic [1:0] w);
    logic [5:0] first;
    logic [5:0] n;
    logic [63:0] m;
    first = {1'b0, w, 3'b000};
    m = '0;
    if ({1'b0, len} > first) begin
      n = {1'b0, len} - first;
      for (int b = 0; b < 8; b++) begin
        if (n > 6'(b)) m[b*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

endpackage

// File: src/station_table_with_aging.sv
`timescale 1ns / 1ps
// Station table with aging.
// Requests arrive on a valid/ready channel (req_type, address, advert bytes,
// current_time). A scan request looks the address up in the table, updates or
// inserts the station, or drops it when the table is full, and returns one
// result. A check request walks every slot, drops stations whose last sighting
// plus max_age_seconds lies before current_time, reports each survivor and
// ends with one statistics result. Results leave on a valid/ready channel;
// last_of_run marks the final one. A single sequencer reads one slot at a
// time. A scan compares slots in order until it finds the address or passes
// the last slot, writes the row back unless the station is dropped, presents
// the result and returns to idle. A check decides each slot in order, gives a
// result for each survivor, then the statistics result, and returns to idle.
// A new request is taken only when the previous one is finished. When the
// receiver stalls the sequencer holds with its result in the output register.
// Reset clears all valid bits, the previous station count, and sets
// max_age_seconds to 60 seconds. The APB port writes and reads that register.
module station_table_with_aging #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic [47:0] station_address_i,
  input  logic [7:0]  address_type_i,
  input  logic signed [7:0] signal_strength_i,
  input  logic [4:0]  advert_length_i,
  input  logic [63:0] advert_word0_i,
  input  logic [63:0] advert_word1_i,
  input  logic [63:0] advert_word2_i,
  input  logic [63:0] advert_word3_i,
  input  logic [31:0] current_time_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  result_kind_o,
  output logic        last_of_run_o,
  output logic [47:0] report_address_o,
  output logic [7:0]  report_type_o,
  output logic signed [7:0] report_strength_o,
  output logic [31:0] report_last_seen_o,
  output logic        report_dirty_o,
  output logic [4:0]  report_length_o,
  output logic [63:0] out_word0_o,
  output logic [63:0] out_word1_o,
  output logic [63:0] out_word2_o,
  output logic [63:0] out_word3_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int RowW = 48 + 8 + 8 + 32 + 1 + 5 + 256;

  // Station memory, one row per slot.
  logic [RowW-1:0] mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [RowW-1:0] rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_wa, rd_addr;
  logic [RowW-1:0] mem_wd;

  sta_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] hit_q, hit_d, free_q, free_d;
  logic            hit_ok_q, hit_ok_d, free_ok_q, free_ok_d;
  logic [CntW-1:0] count_q, count_d, removed_q, removed_d, prev_q, prev_d;
  logic [31:0]     max_age_q;

  // Latched request.
  logic [47:0]     raddr_q;
  logic [7:0]      rat_q, rss_q;
  logic [4:0]      rlen_q;
  logic [255:0]    radv_q;
  logic [31:0]     rnow_q;

  // Output register.
  logic            ovalid_q, ovalid_d;
  logic [RowW+3:0] obuf_q, obuf_d;

  logic [255:0] in_adv;
  logic         accept;
  logic [47:0]  rd_addr_f;
  logic [7:0]   rd_type, rd_str;
  logic [31:0]  rd_seen;
  logic         rd_dirty;
  logic [4:0]   rd_len;
  logic [255:0] rd_adv;
  logic [32:0]  age_sum;
  logic         same;
  logic         last_slot;

  assign in_adv = {advert_word3_i & sta_pkg::byte_mask(advert_length_i, 2'd3),
                   advert_word2_i & sta_pkg::byte_mask(advert_length_i, 2'd2),
                   advert_word1_i & sta_pkg::byte_mask(advert_length_i, 2'd1),
                   advert_word0_i & sta_pkg::byte_mask(advert_length_i, 2'd0)};
  assign accept = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == sta_pkg::StIdle);

  assign {rd_addr_f, rd_type, rd_str, rd_seen, rd_dirty, rd_len, rd_adv} = rd_q;
  assign age_sum = {1'b0, rd_seen} + {1'b0, max_age_q};
  assign same = (rd_type == rat_q) && (rd_len == rlen_q) && (rd_adv == radv_q);
  assign last_slot = (idx_q == IdxW'(TABLE_ENTRIES - 1));

  // APB register port.
  assign pready = 1'b1;
  assign prdata = (paddr == sta_pkg::RegMaxAge) ? max_age_q : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= 32'd60;
    end else if (psel && penable && pwrite && paddr == sta_pkg::RegMaxAge) begin
      max_age_q <= pwdata;
    end
  end

  // Memory with registered read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rd_q <= mem_q[rd_addr];
  end

  // Request latch.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      raddr_q <= station_address_i;
      rat_q   <= address_type_i;
      rss_q   <= signal_strength_i;
      rlen_q  <= advert_length_i;
      radv_q  <= in_adv;
      rnow_q  <= current_time_i;
    end
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sta_pkg::StIdle;
      valid_q   <= '0;
      idx_q     <= '0;
      hit_q     <= '0;
      free_q    <= '0;
      hit_ok_q  <= 1'b0;
      free_ok_q <= 1'b0;
      count_q   <= '0;
      removed_q <= '0;
      prev_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      valid_q   <= valid_d;
      idx_q     <= idx_d;
      hit_q     <= hit_d;
      free_q    <= free_d;
      hit_ok_q  <= hit_ok_d;
      free_ok_q <= free_ok_d;
      count_q   <= count_d;
      removed_q <= removed_d;
      prev_q    <= prev_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obuf_q <= obuf_d;
  end

  // Sequencer: one slot per step through the shared compare.
  always_comb begin
    state_d   = state_q;
    valid_d   = valid_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    free_d    = free_q;
    hit_ok_d  = hit_ok_q;
    free_ok_d = free_ok_q;
    count_d   = count_q;
    removed_d = removed_q;
    prev_d    = prev_q;
    ovalid_d  = ovalid_q;
    obuf_d    = obuf_q;
    mem_we    = 1'b0;
    mem_wa    = idx_q;
    mem_wd    = {raddr_q, rat_q, rss_q, rnow_q, 1'b1, rlen_q, radv_q};
    rd_addr   = idx_q;
    case (state_q)
      sta_pkg::StIdle: begin
        if (accept) begin
          idx_d     = '0;
          hit_ok_d  = 1'b0;
          free_ok_d = 1'b0;
          count_d   = '0;
          removed_d = '0;
          state_d   = (req_type_i == sta_pkg::ReqCheck) ? sta_pkg::StCheckRead
                                                          : sta_pkg::StSearch;
        end
      end
      sta_pkg::StSearch: begin
        // Address compare needs stored address; read slot then compare.
        state_d = sta_pkg::StRead;
      end
      sta_pkg::StRead: begin
        if (valid_q[idx_q]) begin
          if (!hit_ok_q && rd_addr_f == raddr_q) begin
            hit_ok_d = 1'b1;
            hit_d    = idx_q;
          end
        end else if (!free_ok_q) begin
          free_ok_d = 1'b1;
          free_d    = idx_q;
        end
        if (last_slot || (valid_q[idx_q] && rd_addr_f == raddr_q)) begin
          rd_addr = (valid_q[idx_q] && rd_addr_f == raddr_q) ? idx_q : hit_q;
          state_d = sta_pkg::StDecide;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = sta_pkg::StSearch;
        end
      end
      sta_pkg::StDecide: begin
        // rd_q now holds the hit slot's row when there is a hit.
        if (hit_ok_q) begin
          mem_we = 1'b1;
          mem_wa = hit_q;
          if (same) begin
            mem_wd = {rd_addr_f, rd_type, rss_q, rnow_q, 1'b0, rd_len, rd_adv};
            obuf_d = {sta_pkg::KindSame, 1'b1, mem_wd};
          end else begin
            obuf_d = {sta_pkg::KindChanged, 1'b1, mem_wd};
          end
        end else if (free_ok_q) begin
          mem_we = 1'b1;
          mem_wa = free_q;
          valid_d[free_q] = 1'b1;
          obuf_d = {sta_pkg::KindInsert, 1'b1, mem_wd};
        end else begin
          obuf_d = {sta_pkg::KindDropped, 1'b1,
                    raddr_q, rat_q, rss_q, rnow_q, 1'b0, rlen_q, radv_q};
        end
        ovalid_d = 1'b1;
        state_d  = sta_pkg::StOut;
      end
      sta_pkg::StCheckRead: begin
        state_d = sta_pkg::StCheckDecide;
      end
      sta_pkg::StCheckDecide: begin
        if (valid_q[idx_q]) begin
          count_d = count_q + 1'b1;
          if ({1'b0, rnow_q} > age_sum) begin
            valid_d[idx_q] = 1'b0;
            removed_d = removed_q + 1'b1;
          end else begin
            obuf_d   = {sta_pkg::KindReport, 1'b0, rd_q};
            ovalid_d = 1'b1;
            state_d  = sta_pkg::StOut;
          end
        end
        if (state_d != sta_pkg::StOut) begin
          if (last_slot) begin
            state_d = sta_pkg::StStats;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = sta_pkg::StCheckRead;
          end
        end
      end
      sta_pkg::StStats: begin
        obuf_d = '0;
        obuf_d[RowW+3:RowW] = {sta_pkg::KindStats, 1'b1};
        obuf_d[63:0]    = 64'(count_q);
        obuf_d[127:64]  = 64'(count_q - removed_q);
        obuf_d[191:128] = 64'(removed_q);
        obuf_d[255:192] = (count_q > prev_q) ? 64'(count_q - prev_q) : 64'd0;
        prev_d   = count_q - removed_q;
        ovalid_d = 1'b1;
        state_d  = sta_pkg::StOut;
      end
      sta_pkg::StOut: begin
        if (out_ready_i) begin
          ovalid_d = 1'b0;
          if (obuf_q[RowW]) begin
            state_d = sta_pkg::StIdle;
          end else if (last_slot) begin
            state_d = sta_pkg::StStats;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = sta_pkg::StCheckRead;
          end
        end
      end
      default: state_d = sta_pkg::StIdle;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign {result_kind_o, last_of_run_o, report_address_o, report_type_o,
          report_strength_o, report_last_seen_o, report_dirty_o, report_length_o,
          out_word3_o, out_word2_o, out_word1_o, out_word0_o} = obuf_q;

  // Results are only shown from the output state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == sta_pkg::StOut)
    else $error("result valid outside output state");

  // No request is taken while a result waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("ready while result pending");

  // Removed count never exceeds the counted stations.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    removed_q <= count_q)
    else $error("removed count above station count");

  // A stalled result keeps its last mark.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(last_of_run_o))
    else $error("last mark changed during stall");

endmodule
